[hw/rtl/hcad_pkg.sv]
// ----------------------------------------------------------------------------
// hcad_pkg
// Shared types, constants and a helper function for the hazard class alarm
// decision block.
// ----------------------------------------------------------------------------
package hcad_pkg;

    // accumulator width default
    localparam int ACC_WIDTH_DEF = 48;

    // field widths
    localparam int PROB_W  = 16;
    localparam int RATIO_W = 32;
    localparam int CLASS_W = 3;
    localparam int LEVEL_W = 3;
    localparam int MASK_W  = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam int N_CLASSES = 5;
    localparam int N_HAZARD  = 4;

    // Q1.15 one, upper clamp of the chronic ratio for level finding
    localparam logic [PROB_W-1:0] Q_ONE = 16'd32768;

    // register reset values
    localparam logic [PROB_W-1:0]  RST_LEVEL_CAUTION   = 16'd6554;
    localparam logic [PROB_W-1:0]  RST_LEVEL_WARNING   = 16'd14746;
    localparam logic [PROB_W-1:0]  RST_LEVEL_FAST      = 16'd22938;
    localparam logic [PROB_W-1:0]  RST_LEVEL_EMERGENCY = 16'd27853;
    localparam logic [PROB_W-1:0]  RST_CLASS_CONF      = 16'd16384;
    localparam logic [RATIO_W-1:0] RST_DOSE_REF_TICKS  = 32'd28800;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LEVEL_CAUTION   = 3'd0,
        REG_LEVEL_WARNING   = 3'd1,
        REG_LEVEL_FAST      = 3'd2,
        REG_LEVEL_EMERGENCY = 3'd3,
        REG_CLASS_CONF      = 3'd4,
        REG_DOSE_REF_TICKS  = 3'd5
    } t_cfg_reg;

    // warning led levels
    typedef enum logic [LEVEL_W-1:0] {
        WARN_OFF       = 3'd0,
        WARN_SLOW      = 3'd1,
        WARN_FAST      = 3'd2,
        WARN_SOLID     = 3'd3,
        WARN_EMERGENCY = 3'd4
    } t_warn;

    // controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_CALC,
        S_DIV,
        S_DONE
    } t_state;

    // controller to datapath commands
    typedef struct packed {
        logic load_in;
        logic calc;
        logic div_step;
        logic load_out;
    } t_ctrl_cmd;

    // datapath to controller status
    typedef struct packed {
        logic div_last;
    } t_dp_status;

    // level from bounds tested in order, first bound strictly above wins
    function automatic t_warn level_of(
        input logic [PROB_W-1:0] v,
        input logic [PROB_W-1:0] b_caution,
        input logic [PROB_W-1:0] b_warning,
        input logic [PROB_W-1:0] b_fast,
        input logic [PROB_W-1:0] b_emergency
    );
        t_warn lvl;
        if (v < b_caution) begin
            lvl = WARN_OFF;
        end else if (v < b_warning) begin
            lvl = WARN_SLOW;
        end else if (v < b_fast) begin
            lvl = WARN_FAST;
        end else if (v < b_emergency) begin
            lvl = WARN_SOLID;
        end else begin
            lvl = WARN_EMERGENCY;
        end
        return lvl;
    endfunction

endpackage

[hw/rtl/hcad_ctrl.sv]
// ----------------------------------------------------------------------------
// hcad_ctrl
// Sequencer: takes a word, runs the decision step and the serial divider,
// then hands the result to the output register.
// ----------------------------------------------------------------------------
module hcad_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    output logic                   o_valid,
    input  logic                   i_ready,
    input  hcad_pkg::t_dp_status   i_status,
    output hcad_pkg::t_ctrl_cmd    o_cmd
);

    hcad_pkg::t_state r_state;
    hcad_pkg::t_state n_state;
    logic             r_out_valid;
    logic             n_out_valid;
    logic             out_free;

    // output slot is free when empty or being taken this cycle
    assign out_free = !r_out_valid || i_ready;

    // state and output valid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= hcad_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            hcad_pkg::S_IDLE: begin
                // no word is taken while reset is held
                o_ready = i_rst_n;
                if (i_valid && i_rst_n) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = hcad_pkg::S_CALC;
                end
            end
            hcad_pkg::S_CALC: begin
                o_cmd.calc = 1'b1;
                n_state    = hcad_pkg::S_DIV;
            end
            hcad_pkg::S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = hcad_pkg::S_DONE;
                end
            end
            hcad_pkg::S_DONE: begin
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = hcad_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = hcad_pkg::S_IDLE;
            end
        endcase
    end

    // result word held until taken
    always_comb begin
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_valid = r_out_valid;

endmodule

[hw/rtl/hcad_datapath.sv]
// ----------------------------------------------------------------------------
// hcad_datapath
// Configuration registers, class selection, dose accumulator, restoring
// divider for the chronic ratio and the result register.
// ----------------------------------------------------------------------------
module hcad_datapath #(
    parameter int ACC_WIDTH = hcad_pkg::ACC_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  hcad_pkg::t_ctrl_cmd               i_cmd,
    output hcad_pkg::t_dp_status              o_status,
    input  logic                              i_cfg_valid,
    input  logic [hcad_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [hcad_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic [hcad_pkg::PROB_W-1:0]       i_prob_0,
    input  logic [hcad_pkg::PROB_W-1:0]       i_prob_1,
    input  logic [hcad_pkg::PROB_W-1:0]       i_prob_2,
    input  logic [hcad_pkg::PROB_W-1:0]       i_prob_3,
    input  logic [hcad_pkg::PROB_W-1:0]       i_prob_4,
    output logic [hcad_pkg::CLASS_W-1:0]      o_top_class,
    output logic [hcad_pkg::PROB_W-1:0]       o_top_score,
    output logic [hcad_pkg::PROB_W-1:0]       o_severity,
    output logic [hcad_pkg::RATIO_W-1:0]      o_dose_ratio,
    output logic [hcad_pkg::MASK_W-1:0]       o_fire_led_mask,
    output logic [hcad_pkg::LEVEL_W-1:0]      o_warn_level
);

    localparam int PW   = hcad_pkg::PROB_W;
    localparam int RW   = hcad_pkg::RATIO_W;
    localparam int CNTW = (ACC_WIDTH > 1) ? $clog2(ACC_WIDTH) : 1;

    // configuration registers
    logic [PW-1:0] r_lvl_caution;
    logic [PW-1:0] r_lvl_warning;
    logic [PW-1:0] r_lvl_fast;
    logic [PW-1:0] r_lvl_emergency;
    logic [PW-1:0] r_class_conf;
    logic [RW-1:0] r_dose_ref;

    // working registers
    logic [PW-1:0]                  r_prob [hcad_pkg::N_CLASSES];
    logic [hcad_pkg::CLASS_W-1:0]   r_top;
    logic [PW-1:0]                  r_top_score;
    logic [PW-1:0]                  r_sev;
    logic [hcad_pkg::MASK_W-1:0]    r_mask;
    logic [ACC_WIDTH-1:0]           r_acc;
    logic [ACC_WIDTH-1:0]           r_dvd;
    logic [RW-1:0]                  r_rem;
    logic [RW-1:0]                  r_dvs;
    logic [CNTW-1:0]                r_cnt;

    logic [hcad_pkg::CLASS_W-1:0]   top;
    logic [PW-1:0]                  top_score;
    logic [PW-1:0]                  sev;
    logic [hcad_pkg::MASK_W-1:0]    mask;
    logic [ACC_WIDTH:0]             acc_sum;
    logic [ACC_WIDTH-1:0]           n_acc;
    logic [RW:0]                    trial;
    logic [RW:0]                    trial_sub;
    logic                           ratio_ovf;
    logic [RW-1:0]                  ratio;
    logic [PW-1:0]                  ratio_clamp;
    hcad_pkg::t_warn                lvl_sev;
    hcad_pkg::t_warn                lvl_chr;

    // configuration writes, unknown indexes dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lvl_caution   <= hcad_pkg::RST_LEVEL_CAUTION;
            r_lvl_warning   <= hcad_pkg::RST_LEVEL_WARNING;
            r_lvl_fast      <= hcad_pkg::RST_LEVEL_FAST;
            r_lvl_emergency <= hcad_pkg::RST_LEVEL_EMERGENCY;
            r_class_conf    <= hcad_pkg::RST_CLASS_CONF;
            r_dose_ref      <= hcad_pkg::RST_DOSE_REF_TICKS;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                hcad_pkg::REG_LEVEL_CAUTION:   r_lvl_caution   <= i_cfg_data[PW-1:0];
                hcad_pkg::REG_LEVEL_WARNING:   r_lvl_warning   <= i_cfg_data[PW-1:0];
                hcad_pkg::REG_LEVEL_FAST:      r_lvl_fast      <= i_cfg_data[PW-1:0];
                hcad_pkg::REG_LEVEL_EMERGENCY: r_lvl_emergency <= i_cfg_data[PW-1:0];
                hcad_pkg::REG_CLASS_CONF:      r_class_conf    <= i_cfg_data[PW-1:0];
                hcad_pkg::REG_DOSE_REF_TICKS:  r_dose_ref      <= i_cfg_data[RW-1:0];
                default: begin
                end
            endcase
        end
    end

    // input word capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_prob[0] <= i_prob_0;
            r_prob[1] <= i_prob_1;
            r_prob[2] <= i_prob_2;
            r_prob[3] <= i_prob_3;
            r_prob[4] <= i_prob_4;
        end
    end

    // top class, lowest index kept on ties, and severity over hazard classes
    always_comb begin
        top       = '0;
        top_score = r_prob[0];
        for (int i = 1; i < hcad_pkg::N_CLASSES; i++) begin
            if (r_prob[i] > top_score) begin
                top       = hcad_pkg::CLASS_W'(i);
                top_score = r_prob[i];
            end
        end
        sev = '0;
        for (int i = 0; i < hcad_pkg::N_HAZARD; i++) begin
            if (r_prob[i] > sev) begin
                sev = r_prob[i];
            end
        end
    end

    // confident hazard class lights its led
    always_comb begin
        mask = '0;
        if (top < hcad_pkg::CLASS_W'(hcad_pkg::N_HAZARD) && top_score > r_class_conf) begin
            mask = hcad_pkg::MASK_W'(1) << top[1:0];
        end
    end

    // saturating dose accumulation
    assign acc_sum = {1'b0, r_acc} + (ACC_WIDTH + 1)'(sev);
    assign n_acc   = acc_sum[ACC_WIDTH] ? '1 : acc_sum[ACC_WIDTH-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (i_cmd.calc) begin
            r_acc <= n_acc;
        end
    end

    // decision results held for the output stage
    always_ff @(posedge i_clk) begin
        if (i_cmd.calc) begin
            r_top       <= top;
            r_top_score <= top_score;
            r_sev       <= sev;
            r_mask      <= mask;
        end
    end

    // restoring divider, one quotient bit per cycle, quotient shifts into r_dvd
    assign trial     = {r_rem, r_dvd[ACC_WIDTH-1]};
    assign trial_sub = trial - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.calc) begin
            r_cnt <= CNTW'(ACC_WIDTH - 1);
        end else if (i_cmd.div_step) begin
            r_cnt <= r_cnt - CNTW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.calc) begin
            r_dvd <= n_acc;
            r_rem <= '0;
            r_dvs <= (r_dose_ref == '0) ? RW'(1) : r_dose_ref;
        end else if (i_cmd.div_step) begin
            if (!trial_sub[RW]) begin
                r_rem <= trial_sub[RW-1:0];
                r_dvd <= {r_dvd[ACC_WIDTH-2:0], 1'b1};
            end else begin
                r_rem <= trial[RW-1:0];
                r_dvd <= {r_dvd[ACC_WIDTH-2:0], 1'b0};
            end
        end
    end

    assign o_status.div_last = (r_cnt == '0);

    // ratio saturation and warning level
    assign ratio_ovf   = (r_dvd >> RW) != '0;
    assign ratio       = ratio_ovf ? '1 : r_dvd[RW-1:0];
    assign ratio_clamp = (ratio > RW'(hcad_pkg::Q_ONE)) ? hcad_pkg::Q_ONE : ratio[PW-1:0];
    assign lvl_sev     = hcad_pkg::level_of(r_sev, r_lvl_caution, r_lvl_warning,
                                            r_lvl_fast, r_lvl_emergency);
    assign lvl_chr     = hcad_pkg::level_of(ratio_clamp, r_lvl_caution, r_lvl_warning,
                                            r_lvl_fast, r_lvl_emergency);

    // output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_top_class     <= r_top;
            o_top_score     <= r_top_score;
            o_severity      <= r_sev;
            o_dose_ratio    <= ratio;
            o_fire_led_mask <= r_mask;
            o_warn_level    <= (lvl_sev > lvl_chr) ? lvl_sev : lvl_chr;
        end
    end

endmodule

[hw/rtl/hazard_class_alarm_decision.sv]
// ----------------------------------------------------------------------------
// hazard_class_alarm_decision
// Picks the top class, accumulates dose and sets fire and warning leds.
//
//   channel   signals                              direction
//   input     i_valid, o_ready, i_prob_0..4        word in
//   output    o_valid, i_ready, o_top_class..      word out
//   config    i_cfg_valid, o_cfg_ready, index/data register write
//
// an accepted word is captured, then the decision step and the restoring
// divider, one quotient bit a cycle, run before the result reaches the
// output register; no new word is accepted before that, and the next one is
// accepted the cycle after the previous result reaches the output register
// a result waiting for i_ready holds the next finished word in the sequencer
// synchronous active-low reset restores defaults, clears the dose, drops ready
// ----------------------------------------------------------------------------
module hazard_class_alarm_decision #(
    parameter int ACC_WIDTH = hcad_pkg::ACC_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [hcad_pkg::PROB_W-1:0]       i_prob_0,
    input  logic [hcad_pkg::PROB_W-1:0]       i_prob_1,
    input  logic [hcad_pkg::PROB_W-1:0]       i_prob_2,
    input  logic [hcad_pkg::PROB_W-1:0]       i_prob_3,
    input  logic [hcad_pkg::PROB_W-1:0]       i_prob_4,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [hcad_pkg::CLASS_W-1:0]      o_top_class,
    output logic [hcad_pkg::PROB_W-1:0]       o_top_score,
    output logic [hcad_pkg::PROB_W-1:0]       o_severity,
    output logic [hcad_pkg::RATIO_W-1:0]      o_dose_ratio,
    output logic [hcad_pkg::MASK_W-1:0]       o_fire_led_mask,
    output logic [hcad_pkg::LEVEL_W-1:0]      o_warn_level,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [hcad_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [hcad_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    hcad_pkg::t_ctrl_cmd  cmd;
    hcad_pkg::t_dp_status status;

    // register writes are taken whenever out of reset
    assign o_cfg_ready = i_rst_n;

    // sequencer
    hcad_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    // datapath
    hcad_datapath #(
        .ACC_WIDTH (ACC_WIDTH)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_prob_0        (i_prob_0),
        .i_prob_1        (i_prob_1),
        .i_prob_2        (i_prob_2),
        .i_prob_3        (i_prob_3),
        .i_prob_4        (i_prob_4),
        .o_top_class     (o_top_class),
        .o_top_score     (o_top_score),
        .o_severity      (o_severity),
        .o_dose_ratio    (o_dose_ratio),
        .o_fire_led_mask (o_fire_led_mask),
        .o_warn_level    (o_warn_level)
    );

endmodule

[bench/tb_hazard_class_alarm_decision.sv]
// ----------------------------------------------------------------------------
// tb_hazard_class_alarm_decision
// Self-checking bench for the hazard class alarm decision block. A directed
// table covers reset behaviour, ties, probabilities above one and the level
// bound edges. Random phases follow, each under its own register settings,
// most with handshake idling. A short run at full severity with unit
// reference ticks then drives the chronic ratio far past one. Every result
// word is compared field by field with an in-bench model or a typed row.
// ----------------------------------------------------------------------------
module tb_hazard_class_alarm_decision;

    import hcad_pkg::*;

    // default accumulator width
    localparam int ACC_W = ACC_WIDTH_DEF;
    localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};
    localparam int LATENCY = ACC_W + 3;
    localparam int unsigned CYCLE_LIMIT = 1_000_000;

    // indexes beyond the register file, writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

    typedef logic [N_CLASSES-1:0][PROB_W-1:0] t_probs;

    typedef struct packed {
        logic [CLASS_W-1:0] top_class;
        logic [PROB_W-1:0]  top_score;
        logic [PROB_W-1:0]  severity;
        logic [RATIO_W-1:0] dose_ratio;
        logic [MASK_W-1:0]  fire_mask;
        t_warn              warn_level;
    } t_alarm;

    typedef struct packed {
        logic [PROB_W-1:0] p0;
        logic [PROB_W-1:0] p1;
        logic [PROB_W-1:0] p2;
        logic [PROB_W-1:0] p3;
        logic [PROB_W-1:0] p4;
        logic              typed;
        t_alarm            want;
    } t_dir_row;

    localparam t_alarm NO_EXP = '0;
    localparam int N_DIR = 22;

    // directed words; expected alarm typed in only where obvious
    localparam t_dir_row DIR_TABLE [N_DIR] = '{
        '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b1,
          '{3'd0, 16'd0, 16'd0, 32'd0, 4'b0000, WARN_OFF}},
        '{16'd0, 16'd0, 16'd0, 16'd0, 16'd32768, 1'b1,
          '{3'd4, 16'd32768, 16'd0, 32'd0, 4'b0000, WARN_OFF}},
        '{16'd0, 16'd0, 16'd0, 16'd0, 16'hFFFF, 1'b1,
          '{3'd4, 16'hFFFF, 16'd0, 32'd0, 4'b0000, WARN_OFF}},
        '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1,
          '{3'd0, 16'hFFFF, 16'hFFFF, 32'd2, 4'b0001, WARN_EMERGENCY}},
        '{16'd0, 16'd16384, 16'd0, 16'd0, 16'd0, 1'b0, NO_EXP},
        '{16'd0, 16'd16385, 16'd0, 16'd0, 16'd0, 1'b0, NO_EXP},
        '{16'd1000, 16'd1000, 16'd1000, 16'd1000, 16'd1000, 1'b0, NO_EXP},
        '{16'd100, 16'd100, 16'd20000, 16'd20000, 16'd5000, 1'b0, NO_EXP},
        '{16'd30000, 16'd0, 16'd0, 16'd0, 16'd30000, 1'b0, NO_EXP},
        '{16'd1000, 16'd0, 16'd0, 16'd30000, 16'd30000, 1'b0, NO_EXP},
        '{16'd0, 16'd0, 16'd0, 16'd30000, 16'd32768, 1'b0, NO_EXP},
        '{16'd0, 16'd0, 16'd0, 16'd32768, 16'd0, 1'b0, NO_EXP},
        '{16'd0, 16'd0, 16'd6553, 16'd0, 16'd0, 1'b0, NO_EXP},
        '{16'd0, 16'd0, 16'd6554, 16'd0, 16'd0, 1'b0, NO_EXP},
        '{16'd0, 16'd0, 16'd14745, 16'd0, 16'd0, 1'b0, NO_EXP},
        '{16'd0, 16'd0, 16'd14746, 16'd0, 16'd0, 1'b0, NO_EXP},
        '{16'd0, 16'd0, 16'd22937, 16'd0, 16'd0, 1'b0, NO_EXP},
        '{16'd0, 16'd0, 16'd22938, 16'd0, 16'd0, 1'b0, NO_EXP},
        '{16'd0, 16'd0, 16'd27852, 16'd0, 16'd0, 1'b0, NO_EXP},
        '{16'd0, 16'd0, 16'd27853, 16'd0, 16'd0, 1'b0, NO_EXP},
        '{16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 1'b0, NO_EXP},
        '{16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 1'b0, NO_EXP}
    };

    // block ports
    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_ready;
    logic [PROB_W-1:0]     i_prob_0 = '0;
    logic [PROB_W-1:0]     i_prob_1 = '0;
    logic [PROB_W-1:0]     i_prob_2 = '0;
    logic [PROB_W-1:0]     i_prob_3 = '0;
    logic [PROB_W-1:0]     i_prob_4 = '0;
    logic                  o_valid;
    logic                  i_ready = 1'b0;
    logic [CLASS_W-1:0]    o_top_class;
    logic [PROB_W-1:0]     o_top_score;
    logic [PROB_W-1:0]     o_severity;
    logic [RATIO_W-1:0]    o_dose_ratio;
    logic [MASK_W-1:0]     o_fire_led_mask;
    logic [LEVEL_W-1:0]    o_warn_level;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    // model state and register copies
    logic [ACC_W-1:0]   dose_acc;
    logic [PROB_W-1:0]  lvl_bound [4];
    logic [PROB_W-1:0]  conf_bound;
    logic [RATIO_W-1:0] ref_ticks;

    t_alarm pending_alarms [$];

    int send_pct = 0;
    int recv_pct = 0;
    int errors = 0;
    int words_sent = 0;
    int alarms_checked = 0;
    int cfg_writes = 0;
    int soak_words = 0;
    int unsigned cycle_cnt = 0;

    hazard_class_alarm_decision #(
        .ACC_WIDTH(ACC_W)
    ) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_prob_0(i_prob_0),
        .i_prob_1(i_prob_1),
        .i_prob_2(i_prob_2),
        .i_prob_3(i_prob_3),
        .i_prob_4(i_prob_4),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_top_class(o_top_class),
        .o_top_score(o_top_score),
        .o_severity(o_severity),
        .o_dose_ratio(o_dose_ratio),
        .o_fire_led_mask(o_fire_led_mask),
        .o_warn_level(o_warn_level),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data)
    );

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d alarms outstanding",
                     cycle_cnt, pending_alarms.size());
            $display("hazard_class_alarm_decision regression: fail");
            $finish;
        end
    end

    // level search: the first bound the value sits below decides
    function automatic t_warn warn_for(input logic [PROB_W-1:0] v);
        t_warn lvl;
        lvl = WARN_EMERGENCY;
        for (int k = 3; k >= 0; k--) begin
            if (v < lvl_bound[k]) lvl = t_warn'(k);
        end
        return lvl;
    endfunction

    // alarm word for one probability word, advancing the dose
    function automatic t_alarm predict_alarm(input t_probs p);
        t_alarm a;
        int top;
        logic [PROB_W-1:0] sev;
        logic [63:0] ratio;
        logic [PROB_W-1:0] clamped;
        t_warn ws;
        t_warn wc;
        top = 0;
        sev = '0;
        for (int k = 1; k < N_CLASSES; k++) begin
            if (p[k] > p[top]) top = k;
        end
        for (int k = 0; k < N_HAZARD; k++) begin
            if (p[k] > sev) sev = p[k];
        end
        // saturating dose
        if (dose_acc > ACC_MAX - ACC_W'(sev)) dose_acc = ACC_MAX;
        else dose_acc = dose_acc + ACC_W'(sev);
        ratio = 64'(dose_acc) / ((ref_ticks == '0) ? 64'd1 : 64'(ref_ticks));
        if (ratio > 64'hFFFF_FFFF) ratio = 64'hFFFF_FFFF;
        clamped = (ratio > 64'(Q_ONE)) ? Q_ONE : ratio[PROB_W-1:0];
        ws = warn_for(sev);
        wc = warn_for(clamped);
        a.top_class = CLASS_W'(top);
        a.top_score = p[top];
        a.severity = sev;
        a.dose_ratio = ratio[RATIO_W-1:0];
        a.fire_mask = '0;
        if (top < N_HAZARD && p[top] > conf_bound) a.fire_mask[top] = 1'b1;
        a.warn_level = (ws > wc) ? ws : wc;
        return a;
    endfunction

    // one random probability, biased towards edges
    function automatic logic [PROB_W-1:0] rand_prob();
        logic [PROB_W-1:0] v;
        case ($urandom_range(0, 15))
            0: v = '0;
            1: v = Q_ONE;
            2: v = 16'hFFFF;
            3: v = PROB_W'($urandom_range(0, 65535));
            4: v = lvl_bound[$urandom_range(0, 3)] + PROB_W'($urandom_range(0, 2)) - 16'd1;
            5: v = conf_bound + PROB_W'($urandom_range(0, 2)) - 16'd1;
            default: v = PROB_W'($urandom_range(0, 32768));
        endcase
        return v;
    endfunction

    // mostly classifier-like words summing to one, the rest raw noise
    function automatic t_probs random_word();
        t_probs p;
        int left;
        int win;
        int share;
        if ($urandom_range(0, 9) < 6) begin
            left = 32768;
            win = $urandom_range(0, N_CLASSES - 1);
            for (int k = 0; k < N_CLASSES; k++) begin
                if (k != win) begin
                    share = $urandom_range(0, left / 3);
                    p[k] = PROB_W'(share);
                    left -= share;
                end
            end
            p[win] = PROB_W'(left);
        end else begin
            for (int k = 0; k < N_CLASSES; k++) p[k] = rand_prob();
        end
        // forced tie between two classes
        if ($urandom_range(0, 3) == 0) begin
            p[$urandom_range(0, N_CLASSES - 1)] = p[$urandom_range(0, N_CLASSES - 1)];
        end
        return p;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    // result side: check accepted words, then pick next ready
    always @(posedge i_clk) begin
        t_alarm want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_alarms.size() == 0) begin
                $display("%0t: alarm word with none expected, class %0d ratio %0d",
                         $time, o_top_class, o_dose_ratio);
                errors++;
            end else begin
                want = pending_alarms.pop_front();
                check_field("top_class", 32'(want.top_class), 32'(o_top_class));
                check_field("top_score", 32'(want.top_score), 32'(o_top_score));
                check_field("severity", 32'(want.severity), 32'(o_severity));
                check_field("dose_ratio", want.dose_ratio, o_dose_ratio);
                check_field("fire_led_mask", 32'(want.fire_mask), 32'(o_fire_led_mask));
                check_field("warn_level", 32'(want.warn_level), 32'(o_warn_level));
                alarms_checked++;
            end
        end
        i_ready <= ($urandom_range(0, 99) >= recv_pct);
    end

    // present one word, idling first at random, and book its alarm
    task automatic send_word(input t_probs p, input logic typed, input t_alarm typed_exp);
        int gap;
        t_alarm a;
        gap = 0;
        while (gap < 6 && $urandom_range(0, 99) < send_pct) gap++;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_prob_0 <= p[0];
        i_prob_1 <= p[1];
        i_prob_2 <= p[2];
        i_prob_3 <= p[3];
        i_prob_4 <= p[4];
        do @(posedge i_clk); while (!o_ready);
        a = predict_alarm(p);
        pending_alarms.push_back(typed ? typed_exp : a);
        words_sent++;
    endtask

    task automatic wait_drained();
        @(posedge i_clk);
        while (pending_alarms.size() != 0) @(posedge i_clk);
    endtask

    // register write, only once every alarm is out
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        cfg_writes++;
        case (idx)
            REG_LEVEL_CAUTION:   lvl_bound[0] = data[PROB_W-1:0];
            REG_LEVEL_WARNING:   lvl_bound[1] = data[PROB_W-1:0];
            REG_LEVEL_FAST:      lvl_bound[2] = data[PROB_W-1:0];
            REG_LEVEL_EMERGENCY: lvl_bound[3] = data[PROB_W-1:0];
            REG_CLASS_CONF:      conf_bound = data[PROB_W-1:0];
            REG_DOSE_REF_TICKS:  ref_ticks = data;
            default: ;
        endcase
    endtask

    // full register set, junk in the unused upper bits of the 16-bit ones
    task automatic write_levels(input logic [PROB_W-1:0] c, input logic [PROB_W-1:0] w,
                                input logic [PROB_W-1:0] f, input logic [PROB_W-1:0] e,
                                input logic [PROB_W-1:0] conf,
                                input logic [RATIO_W-1:0] ticks);
        cfg_write(REG_LEVEL_CAUTION, {16'($urandom), c});
        cfg_write(REG_LEVEL_WARNING, {16'($urandom), w});
        cfg_write(REG_LEVEL_FAST, {16'($urandom), f});
        cfg_write(REG_LEVEL_EMERGENCY, {16'($urandom), e});
        cfg_write(REG_CLASS_CONF, {16'($urandom), conf});
        cfg_write(REG_DOSE_REF_TICKS, ticks);
    endtask

    task automatic run_phase(input int n_words, input int s_pct, input int r_pct);
        send_pct = s_pct;
        recv_pct = r_pct;
        for (int n = 0; n < n_words; n++) send_word(random_word(), 1'b0, NO_EXP);
        i_valid <= 1'b0;
    endtask

    // reference ticks chosen so the chronic ratio lands near a random target
    function automatic logic [RATIO_W-1:0] ticks_for_ratio();
        return RATIO_W'(dose_acc / ACC_W'($urandom_range(1, 40000)));
    endfunction

    // ascending random bounds inside 0..1.0
    task automatic write_ascending(input logic [RATIO_W-1:0] ticks);
        logic [PROB_W-1:0] c;
        logic [PROB_W-1:0] w;
        logic [PROB_W-1:0] f;
        logic [PROB_W-1:0] e;
        c = PROB_W'($urandom_range(0, 8192));
        w = c + PROB_W'($urandom_range(0, 8192));
        f = w + PROB_W'($urandom_range(0, 8192));
        e = f + PROB_W'($urandom_range(0, 8192));
        write_levels(c, w, f, e, PROB_W'($urandom_range(0, 32768)), ticks);
    endtask

    // stimulus
    initial begin
        t_probs w;
        t_dir_row row;
        dose_acc = '0;
        lvl_bound[0] = RST_LEVEL_CAUTION;
        lvl_bound[1] = RST_LEVEL_WARNING;
        lvl_bound[2] = RST_LEVEL_FAST;
        lvl_bound[3] = RST_LEVEL_EMERGENCY;
        conf_bound = RST_CLASS_CONF;
        ref_ticks = RST_DOSE_REF_TICKS;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table at reset settings
        for (int r = 0; r < N_DIR; r++) begin
            row = DIR_TABLE[r];
            w[0] = row.p0;
            w[1] = row.p1;
            w[2] = row.p2;
            w[3] = row.p3;
            w[4] = row.p4;
            send_word(w, row.typed, row.want);
        end
        i_valid <= 1'b0;
        wait_drained();

        // reset settings, no idling
        run_phase(165, 0, 0);

        // all bounds zero, zero reference ticks acting as one
        write_levels('0, '0, '0, '0, '0, '0);
        run_phase(165, 0, 0);

        // all bounds at the top, ratio pinned to zero
        write_levels(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
        run_phase(165, 45, 0);

        // unordered bounds
        write_levels(PROB_W'($urandom_range(0, 32768)), PROB_W'($urandom_range(0, 32768)),
                     PROB_W'($urandom_range(0, 32768)), PROB_W'($urandom_range(0, 32768)),
                     PROB_W'($urandom_range(0, 65535)), ticks_for_ratio());
        run_phase(165, 0, 45);

        // ascending bounds, ratio near a random level
        write_ascending(ticks_for_ratio());
        run_phase(165, 20, 20);

        // bounds back to reset values, spare indexes must change nothing
        write_levels(RST_LEVEL_CAUTION, RST_LEVEL_WARNING, RST_LEVEL_FAST,
                     RST_LEVEL_EMERGENCY, RST_CLASS_CONF, ticks_for_ratio());
        cfg_write(REG_SPARE_6, $urandom);
        cfg_write(REG_SPARE_7, $urandom);
        run_phase(165, 20, 20);

        // full severity with unit reference ticks, ratio far above one
        write_levels(RST_LEVEL_CAUTION, RST_LEVEL_WARNING, RST_LEVEL_FAST,
                     RST_LEVEL_EMERGENCY, RST_CLASS_CONF, 32'd1);
        send_pct = 0;
        recv_pct = 0;
        for (int n = 0; n < 40; n++) begin
            w = random_word();
            w[$urandom_range(0, N_HAZARD - 1)] = 16'hFFFF;
            send_word(w, 1'b0, NO_EXP);
            soak_words++;
        end
        i_valid <= 1'b0;

        // high dose under random settings
        write_ascending(32'($urandom));
        run_phase(60, 20, 20);

        wait_drained();
        repeat (LATENCY + 16) @(posedge i_clk);

        $display("covered %0d words (%0d at full severity), %0d alarms checked",
                 words_sent, soak_words, alarms_checked);
        $display("%0d register writes over eight settings, %0d mismatches",
                 cfg_writes, errors);
        if (errors == 0 && pending_alarms.size() == 0) begin
            $display("hazard_class_alarm_decision regression: pass");
        end else begin
            $display("hazard_class_alarm_decision regression: fail");
        end
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/hcad_pkg.sv
hw/rtl/hcad_ctrl.sv
hw/rtl/hcad_datapath.sv
hw/rtl/hazard_class_alarm_decision.sv
bench/tb_hazard_class_alarm_decision.sv
